/* rtl/core/bcfc_pkg.sv */
// ----------------------------------------------------------------------------
// bcfc_pkg
// Shared types and constants of the block-circulant frequency-domain
// convolution engine.
// ----------------------------------------------------------------------------
package bcfc_pkg;

   localparam int STORE_AW    = 16;
   localparam int STORE_DEPTH = 65536;
   localparam int BIAS_AW     = 6;
   localparam int BIAS_DEPTH  = 64;
   localparam int MAX_BLOCK   = 16;
   localparam int LANE_AW     = 4;

   localparam logic [1:0] ACT_FEATURE = 2'd0;
   localparam logic [1:0] ACT_WEIGHT  = 2'd1;
   localparam logic [1:0] ACT_BIAS    = 2'd2;
   localparam logic [1:0] ACT_COMPUTE = 2'd3;

   localparam logic [3:0] REG_IN_CHANNELS  = 4'd0;
   localparam logic [3:0] REG_OUT_CHANNELS = 4'd1;
   localparam logic [3:0] REG_HEIGHT       = 4'd2;
   localparam logic [3:0] REG_WIDTH        = 4'd3;
   localparam logic [3:0] REG_KERNEL       = 4'd4;
   localparam logic [3:0] REG_STRIDE       = 4'd5;
   localparam logic [3:0] REG_PADDING      = 4'd6;
   localparam logic [3:0] REG_BLOCK_SIZE   = 4'd7;

   typedef struct packed {
      logic [1:0]         action;
      logic [15:0]        address;
      logic signed [31:0] value_re;
      logic signed [31:0] value_im;
      logic [5:0]         out_row;
      logic [5:0]         out_col;
      logic [5:0]         out_group;
   } req_type;

   typedef struct packed {
      logic [5:0]         out_channel;
      logic signed [31:0] out_re;
      logic signed [31:0] out_im;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [6:0] in_channels;
      logic [6:0] out_channels;
      logic [5:0] height;
      logic [5:0] width;
      logic [1:0] kernel;
      logic [2:0] stride;
      logic [1:0] padding;
      logic [4:0] block_size;
   } cfg_type;

   // Head of the request queue as seen by the back end.
   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_head_type;

endpackage

/* rtl/core/bcfc_ram.sv */
// ----------------------------------------------------------------------------
// bcfc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcfc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/bcfc_front.sv */
// ----------------------------------------------------------------------------
// bcfc_front
// Request intake: configuration registers and a two-entry request queue.
// ----------------------------------------------------------------------------
module bcfc_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  bcfc_pkg::req_type        req_item,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [3:0]               csr_index,
   input  logic [7:0]               csr_data,
   output bcfc_pkg::cfg_type        cfg,
   output bcfc_pkg::queue_head_type head,
   input  logic                     pop
);

   bcfc_pkg::cfg_type cfg_ff, cfg_in;
   bcfc_pkg::req_type mem_ff [2];
   logic              wptr_ff, rptr_ff;
   logic [1:0]        count_ff, count_in;
   logic              push, do_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            bcfc_pkg::REG_IN_CHANNELS:  cfg_in.in_channels  = csr_data[6:0];
            bcfc_pkg::REG_OUT_CHANNELS: cfg_in.out_channels = csr_data[6:0];
            bcfc_pkg::REG_HEIGHT:       cfg_in.height       = csr_data[5:0];
            bcfc_pkg::REG_WIDTH:        cfg_in.width        = csr_data[5:0];
            bcfc_pkg::REG_KERNEL:       cfg_in.kernel       = csr_data[1:0];
            bcfc_pkg::REG_STRIDE:       cfg_in.stride       = csr_data[2:0];
            bcfc_pkg::REG_PADDING:      cfg_in.padding      = csr_data[1:0];
            bcfc_pkg::REG_BLOCK_SIZE:   cfg_in.block_size   = csr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.in_channels  <= 7'd64;
         cfg_ff.out_channels <= 7'd64;
         cfg_ff.height       <= 6'd32;
         cfg_ff.width        <= 6'd32;
         cfg_ff.kernel       <= 2'd3;
         cfg_ff.stride       <= 3'd1;
         cfg_ff.padding      <= 2'd1;
         cfg_ff.block_size   <= 5'd8;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg    = cfg_ff;
   assign busy   = (count_ff == 2'd2);
   assign push   = start && !busy;
   assign do_pop = pop && (count_ff != 2'd0);

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wptr_ff <= !wptr_ff;
         end
         if (do_pop) begin
            rptr_ff <= !rptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= req_item;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = mem_ff[rptr_ff];

endmodule

/* rtl/core/bcfc_back.sv */
// ----------------------------------------------------------------------------
// bcfc_back
// Execution engine: store writes, bias preload, window walk with one complex
// multiply-accumulate per cycle while in the MAC state, and the result burst.
// ----------------------------------------------------------------------------
module bcfc_back (
   input  logic                     clock,
   input  logic                     reset,
   input  bcfc_pkg::cfg_type        cfg,
   input  bcfc_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   output bcfc_pkg::rsp_type        rsp_item
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SETUP1 = 9'b000000010,
      ST_SETUP2 = 9'b000000100,
      ST_BIAS   = 9'b000001000,
      ST_BIASW  = 9'b000010000,
      ST_TAP    = 9'b000100000,
      ST_TAPMUL = 9'b001000000,
      ST_MAC    = 9'b010000000,
      ST_EMIT   = 9'b100000000
   } state_type;

   // Drain is folded into EMIT entry: see wait condition below.
   state_type state_ff, state_in;
   logic      drain_ff, drain_in;

   bcfc_pkg::req_type cmd_ff;
   logic [4:0]  bs_ff, bs_c;
   logic [3:0]  kk_ff;
   logic [8:0]  kkbs_ff;
   logic [8:0]  orow_s_ff, ocol_s_ff;
   logic [11:0] hw_ff;
   logic [10:0] gb_ff;
   logic [12:0] ogic_ff;
   logic [15:0] obase_ff;
   logic [1:0]  rr_ff, rr_in, cc_ff, cc_in;
   logic [7:0]  tapoff_ff, tapoff_in;
   logic [5:0]  rowp_ff, colp_ff;
   logic [15:0] faddr_ff, faddr_in, wgrp_ff, wgrp_in;
   logic [7:0]  gs_ff, gs_in;
   logic [3:0]  lane_ff, lane_in;

   logic        v1_ff, v2_ff, bv_ff;
   logic [3:0]  lane1_ff, lane2_ff, blane_ff;
   logic signed [15:0] prr_ff, pii_ff, pri_ff, pir_ff;

   logic signed [31:0] acc_re_ff [bcfc_pkg::MAX_BLOCK];
   logic signed [31:0] acc_im_ff [bcfc_pkg::MAX_BLOCK];

   logic [15:0] f_rdata, w_rdata;
   logic [63:0] b_rdata;
   logic        issue;
   logic        lane_last;
   logic        tap_last;
   logic [9:0]  row_c, col_c;
   logic        tap_ok;
   logic [8:0]  gs_next2;
   logic [3:0]  ridx;
   logic        load_we;

   assign bs_c = (cfg.block_size == 5'd0) ? 5'd1 :
                 (cfg.block_size > 5'd16) ? 5'd16 : cfg.block_size;

   assign lane_last = ({1'b0, lane_ff} == (bs_ff - 5'd1));
   assign tap_last  = (cc_ff == cfg.kernel - 2'd1) && (rr_ff == cfg.kernel - 2'd1);
   assign row_c     = {1'b0, orow_s_ff} + {8'd0, rr_ff};
   assign col_c     = {1'b0, ocol_s_ff} + {8'd0, cc_ff};
   assign tap_ok    = (row_c >= {8'd0, cfg.padding}) &&
                      (row_c < ({4'd0, cfg.height} + {8'd0, cfg.padding})) &&
                      (col_c >= {8'd0, cfg.padding}) &&
                      (col_c < ({4'd0, cfg.width} + {8'd0, cfg.padding}));
   assign gs_next2  = {1'b0, gs_ff} + {3'd0, bs_ff, 1'b0};
   assign issue     = (state_ff == ST_MAC);
   assign pop       = (state_ff == ST_IDLE);
   assign load_we   = pop && head.valid;

   always_comb begin
      state_in  = state_ff;
      drain_in  = drain_ff;
      rr_in     = rr_ff;
      cc_in     = cc_ff;
      tapoff_in = tapoff_ff;
      faddr_in  = faddr_ff;
      wgrp_in   = wgrp_ff;
      gs_in     = gs_ff;
      lane_in   = lane_ff;
      case (state_ff)
         ST_IDLE: begin
            if (head.valid && head.item.action == bcfc_pkg::ACT_COMPUTE) begin
               state_in = ST_SETUP1;
            end
         end
         ST_SETUP1: state_in = ST_SETUP2;
         ST_SETUP2: begin
            lane_in  = 4'd0;
            state_in = ST_BIAS;
         end
         ST_BIAS: begin
            lane_in = lane_ff + 4'd1;
            if (lane_last) begin
               state_in = ST_BIASW;
            end
         end
         ST_BIASW: begin
            rr_in     = 2'd0;
            cc_in     = 2'd0;
            tapoff_in = 8'd0;
            lane_in   = 4'd0;
            if (cfg.kernel == 2'd0) begin
               drain_in = 1'b1;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_TAP;
            end
         end
         ST_TAP, ST_TAPMUL, ST_MAC: begin
            // A tap ends when it falls in the padding, has no channel
            // group at all, or its last group has been issued.
            logic tap_done;
            tap_done = 1'b0;
            if (state_ff == ST_TAP) begin
               if (tap_ok) begin
                  state_in = ST_TAPMUL;
               end else begin
                  tap_done = 1'b1;
               end
            end else if (state_ff == ST_TAPMUL) begin
               faddr_in = 16'(({1'b0, rowp_ff} * {1'b0, cfg.width}) + {7'd0, colp_ff});
               wgrp_in  = obase_ff + {8'd0, tapoff_ff};
               gs_in    = 8'd0;
               lane_in  = 4'd0;
               if ({2'd0, bs_ff} <= cfg.in_channels) begin
                  state_in = ST_MAC;
               end else begin
                  tap_done = 1'b1;
               end
            end else begin
               faddr_in = faddr_ff + {4'd0, hw_ff};
               lane_in  = lane_ff + 4'd1;
               if (lane_last) begin
                  lane_in = 4'd0;
                  gs_in   = gs_ff + {3'd0, bs_ff};
                  wgrp_in = wgrp_ff + {7'd0, kkbs_ff};
                  if (gs_next2 > {2'd0, cfg.in_channels}) begin
                     tap_done = 1'b1;
                  end
               end
            end
            if (tap_done) begin
               tapoff_in = tapoff_ff + {3'd0, bs_ff};
               if (cc_ff == cfg.kernel - 2'd1) begin
                  cc_in = 2'd0;
                  rr_in = rr_ff + 2'd1;
               end else begin
                  cc_in = cc_ff + 2'd1;
               end
               lane_in = 4'd0;
               if (tap_last) begin
                  drain_in = 1'b1;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_TAP;
               end
            end
         end
         ST_EMIT: begin
            // The first cycles of EMIT wait for the multiply pipeline to empty.
            if (drain_ff) begin
               if (!v1_ff && !v2_ff && !issue) begin
                  drain_in = 1'b0;
               end
            end else begin
               lane_in = lane_ff + 4'd1;
               if (lane_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         drain_ff <= 1'b0;
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         bv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         drain_ff <= drain_in;
         v1_ff    <= issue;
         v2_ff    <= v1_ff;
         bv_ff    <= (state_ff == ST_BIAS);
      end
   end

   always_ff @(posedge clock) begin
      rr_ff     <= rr_in;
      cc_ff     <= cc_in;
      tapoff_ff <= tapoff_in;
      faddr_ff  <= faddr_in;
      wgrp_ff   <= wgrp_in;
      gs_ff     <= gs_in;
      lane_ff   <= lane_in;
      lane1_ff  <= lane_ff;
      lane2_ff  <= lane1_ff;
      blane_ff  <= lane_ff;
      if (load_we) begin
         cmd_ff <= head.item;
      end
      if (state_ff == ST_SETUP1) begin
         bs_ff     <= bs_c;
         kk_ff     <= {2'd0, cfg.kernel} * {2'd0, cfg.kernel};
         orow_s_ff <= cmd_ff.out_row * cfg.stride;
         ocol_s_ff <= cmd_ff.out_col * cfg.stride;
         hw_ff     <= cfg.height * cfg.width;
         gb_ff     <= cmd_ff.out_group * bs_c;
         ogic_ff   <= cmd_ff.out_group * cfg.in_channels;
      end
      if (state_ff == ST_SETUP2) begin
         kkbs_ff  <= kk_ff * bs_ff;
         obase_ff <= 16'(ogic_ff * kk_ff);
      end
      if (state_ff == ST_TAP) begin
         rowp_ff <= 6'(row_c - {8'd0, cfg.padding});
         colp_ff <= 6'(col_c - {8'd0, cfg.padding});
      end
      prr_ff <= $signed(f_rdata[7:0])  * $signed(w_rdata[7:0]);
      pii_ff <= $signed(f_rdata[15:8]) * $signed(w_rdata[15:8]);
      pri_ff <= $signed(f_rdata[7:0])  * $signed(w_rdata[15:8]);
      pir_ff <= $signed(f_rdata[15:8]) * $signed(w_rdata[7:0]);
      if (bv_ff) begin
         acc_re_ff[blane_ff] <= $signed(b_rdata[31:0]);
         acc_im_ff[blane_ff] <= $signed(b_rdata[63:32]);
      end else if (v2_ff) begin
         if (lane2_ff == 4'd0) begin
            acc_re_ff[lane2_ff] <= acc_re_ff[lane2_ff] + 32'(prr_ff);
            acc_im_ff[lane2_ff] <= acc_im_ff[lane2_ff] + 32'(pii_ff);
         end else begin
            acc_re_ff[lane2_ff] <= acc_re_ff[lane2_ff] + 32'(prr_ff) - 32'(pii_ff);
            acc_im_ff[lane2_ff] <= acc_im_ff[lane2_ff] + 32'(pri_ff) + 32'(pir_ff);
         end
      end
   end

   bcfc_ram #(.WIDTH(16), .DEPTH(bcfc_pkg::STORE_DEPTH)) u_feature (
      .clock (clock),
      .we    (load_we && head.item.action == bcfc_pkg::ACT_FEATURE),
      .waddr (head.item.address),
      .wdata ({head.item.value_im[7:0], head.item.value_re[7:0]}),
      .raddr (faddr_ff),
      .rdata (f_rdata)
   );

   bcfc_ram #(.WIDTH(16), .DEPTH(bcfc_pkg::STORE_DEPTH)) u_weight (
      .clock (clock),
      .we    (load_we && head.item.action == bcfc_pkg::ACT_WEIGHT),
      .waddr (head.item.address),
      .wdata ({head.item.value_im[7:0], head.item.value_re[7:0]}),
      .raddr (wgrp_ff + {12'd0, lane_ff}),
      .rdata (w_rdata)
   );

   bcfc_ram #(.WIDTH(64), .DEPTH(bcfc_pkg::BIAS_DEPTH)) u_bias (
      .clock (clock),
      .we    (load_we && head.item.action == bcfc_pkg::ACT_BIAS),
      .waddr (head.item.address[bcfc_pkg::BIAS_AW-1:0]),
      .wdata ({head.item.value_im, head.item.value_re}),
      .raddr (6'(gb_ff + {7'd0, lane_ff})),
      .rdata (b_rdata)
   );

   assign ridx                 = lane_ff;
   assign rsp_valid            = (state_ff == ST_EMIT) && !drain_ff;
   assign rsp_item.out_channel = 6'(gb_ff + {7'd0, lane_ff});
   assign rsp_item.out_re      = acc_re_ff[ridx];
   assign rsp_item.out_im      = acc_im_ff[ridx];
   assign rsp_item.last        = lane_last;

endmodule

/* rtl/core/block_circulant_freq_conv2d_top.sv */
// ----------------------------------------------------------------------------
// block_circulant_freq_conv2d_top
// Frequency-domain convolution engine for block-circulant layers.
//
// A request is taken on a clock edge with start high and busy low. Loads
// write a feature word, weight word or complex bias into its store. A
// compute request walks the padded, strided k-by-k window over every full
// input channel group and emits block_size results (clamped to 1..16) on
// rsp_valid, one per cycle, with rsp_item.last on the final lane. The
// receiver cannot stall: each result is on the ports for exactly one
// cycle. Two requests queue ahead of the engine; busy is high while the
// queue is full. A compute request is paced by the single multiply-accumulate
// unit and its one-port-per-store reads. Registers are to be written through
// the csr_ channel only while no request is in flight; the block itself does
// not enforce this. Reset empties the queue, idles the engine and restores
// register defaults; store contents are undefined until written.
// ----------------------------------------------------------------------------
module block_circulant_freq_conv2d_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bcfc_pkg::req_type req_item,
   output logic              rsp_valid,
   output bcfc_pkg::rsp_type rsp_item,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [3:0]        csr_index,
   input  logic [7:0]        csr_data
);

   bcfc_pkg::cfg_type        cfg;
   bcfc_pkg::queue_head_type head;
   logic                     pop;

   bcfc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .head      (head),
      .pop       (pop)
   );

   bcfc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   a_last_ends_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |=> !rsp_valid)
      else $error("result strobe continued after the last lane");

   a_full_has_head: assert property (@(posedge clock) disable iff (reset)
      busy |-> head.valid)
      else $error("queue reports full without a head entry");

   a_quiet_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !busy)
      else $error("block not idle right after reset");

   a_no_pop_in_burst: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !pop)
      else $error("engine took a request while emitting results");

endmodule
